// ----- rtl/core/dq_pkg.sv -----
// ============================================================================
// dq_pkg - shared definitions for the double-ended queue
// Request and status codes, controller states and default sizes.
// ============================================================================
`default_nettype none

package dq_pkg;

  // Default number of stored words.
  localparam int DEPTH_DEFAULT = 16;

  // Word width of stored items.
  localparam int WORD_W = 32;

  // Width of the occupancy field for the default depth.
  localparam int OCC_W = $clog2(DEPTH_DEFAULT + 1);

  // Request codes. Code 7 is unused and ignored.
  typedef enum logic [2:0] {
    REQ_PUSH_HEAD = 3'd0,
    REQ_PUSH_TAIL = 3'd1,
    REQ_POP_HEAD  = 3'd2,
    REQ_POP_TAIL  = 3'd3,
    REQ_WALK_FWD  = 3'd4,
    REQ_WALK_REV  = 3'd5,
    REQ_CLEAR     = 3'd6
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/dq_req_if.sv -----
// ============================================================================
// dq_req_if - request channel of the double-ended queue
// Carries the request code and the word to push, with valid and ready.
// ============================================================================
`default_nettype none

interface dq_req_if;

  logic                              valid;
  logic                              ready;
  logic [2:0]                        req_type;
  logic signed [dq_pkg::WORD_W-1:0]  item;

  modport source (output valid, output req_type, output item, input ready);
  modport sink   (input valid, input req_type, input item, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/dq_rsp_if.sv -----
// ============================================================================
// dq_rsp_if - result channel of the double-ended queue
// Carries the result word, status, last flag and occupancy, with valid and ready.
// ============================================================================
`default_nettype none

interface dq_rsp_if #(
  parameter int CW = dq_pkg::OCC_W
);

  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::WORD_W-1:0]  value;
  logic [1:0]                        status;
  logic                              last;
  logic [CW-1:0]                     occupancy;

  modport source (output valid, output value, output status, output last,
                  output occupancy, input ready);
  modport sink   (input valid, input value, input status, input last,
                  input occupancy, output ready);

endinterface

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
// ============================================================================
// double_ended_queue - bounded deque of signed 32-bit words
// Circular word memory addressed by a head pointer and an occupancy count.
// ============================================================================
// The queue holds up to DEPTH signed words in a single synchronous memory with
// a registered read port. Each request transaction yields one result
// transaction, except a walk, which yields one result per stored word with
// last set on the final one, and the unused request code 7, which yields
// nothing. Push and clear finish in the cycle they are accepted, so these
// requests can be accepted every cycle while the result side keeps up. A pop
// first reads the memory, then loads the result. A walk makes one memory
// read per word, issued in the same cycle as the previous word is loaded
// into the output register. Pops and walks of an empty queue answer in the
// cycle they are accepted, with status empty. A push to a full queue is
// dropped and answered with status full and the pushed word echoed. The
// output register decouples the two sides: a new request is taken in the
// same cycle as a waiting result leaves. The rsp interface must be
// instantiated with CW = $clog2(DEPTH + 1).
// ============================================================================
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  wire        clk,
  input  wire        rst,
  dq_req_if.sink     req,
  dq_rsp_if.source   rsp
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = dq_pkg::WORD_W;

  // Depth as sized constants for pointer and count arithmetic.
  localparam logic [IW:0]   DEPTH_S = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  dq_pkg::state_t state, state_next;
  logic [IW-1:0]  head, head_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  walk_idx, walk_idx_next;
  logic           walk_rev, walk_rev_next;

  // Output register.
  logic                 out_valid;
  logic signed [WW-1:0] out_value;
  logic [1:0]           out_status;
  logic                 out_last;
  logic [CW-1:0]        out_occ;

  // Memory ports.
  logic signed [WW-1:0] mem [DEPTH];
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic signed [WW-1:0] wr_data;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic signed [WW-1:0] rd_data;

  // Output load controls.
  logic                 load;
  logic signed [WW-1:0] ld_value;
  dq_pkg::status_t      ld_status;
  logic                 ld_last;

  logic          out_free;
  logic          full;
  logic          empty;
  logic [IW-1:0] head_dec;
  logic [IW-1:0] head_inc;
  logic [IW-1:0] tail_slot;
  logic [IW-1:0] after_tail;
  logic          walk_is_last;
  logic [CW-1:0] walk_nxt;
  logic [CW-1:0] walk_off;

  // Physical slot of a logical offset from the head. Both operands are below
  // DEPTH, so one conditional subtract wraps the sum.
  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h,
                                         input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, h} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IW-1:0];
  endfunction

  // The output register can take a new result when it is empty or its
  // current result leaves in this cycle.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == dq_pkg::S_IDLE) && out_free;

  assign full  = (count == DEPTH_C);
  assign empty = (count == '0);

  assign head_dec   = (head == '0) ? LAST_IX : head - IW'(1);
  assign head_inc   = (head == LAST_IX) ? '0 : head + IW'(1);
  assign after_tail = slot(head, count[IW-1:0]);
  assign tail_slot  = slot(head, IW'(count - CW'(1)));

  // Walk bookkeeping: walk_idx counts results already loaded.
  assign walk_is_last = (walk_idx == count - CW'(1));
  assign walk_nxt     = walk_idx + CW'(1);
  assign walk_off     = walk_rev ? (count - CW'(1) - walk_nxt) : walk_nxt;

  // --------------------------------------------------------------------------
  // Next state and outputs
  // --------------------------------------------------------------------------
  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    walk_idx_next = walk_idx;
    walk_rev_next = walk_rev;
    wr_en         = 1'b0;
    wr_addr       = head;
    wr_data       = req.item;
    rd_en         = 1'b0;
    rd_addr       = head;
    load          = 1'b0;
    ld_value      = '0;
    ld_status     = dq_pkg::ST_OK;
    ld_last       = 1'b1;

    case (state)
      dq_pkg::S_IDLE: begin
        if (req.valid && out_free) begin
          case (req.req_type)
            dq_pkg::REQ_PUSH_HEAD, dq_pkg::REQ_PUSH_TAIL: begin
              load     = 1'b1;
              ld_value = req.item;
              if (full) begin
                ld_status = dq_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + CW'(1);
                if (req.req_type == dq_pkg::REQ_PUSH_HEAD) begin
                  head_next = head_dec;
                  wr_addr   = head_dec;
                end else begin
                  wr_addr = after_tail;
                end
              end
            end
            dq_pkg::REQ_POP_HEAD, dq_pkg::REQ_POP_TAIL: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = dq_pkg::ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                count_next = count - CW'(1);
                state_next = dq_pkg::S_POP;
                if (req.req_type == dq_pkg::REQ_POP_HEAD) begin
                  rd_addr   = head;
                  head_next = head_inc;
                end else begin
                  rd_addr = tail_slot;
                end
              end
            end
            dq_pkg::REQ_WALK_FWD, dq_pkg::REQ_WALK_REV: begin
              if (empty) begin
                load      = 1'b1;
                ld_status = dq_pkg::ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                walk_idx_next = '0;
                walk_rev_next = (req.req_type == dq_pkg::REQ_WALK_REV);
                rd_addr       = (req.req_type == dq_pkg::REQ_WALK_REV) ? tail_slot : head;
                state_next    = dq_pkg::S_WALK;
              end
            end
            dq_pkg::REQ_CLEAR: begin
              load       = 1'b1;
              head_next  = '0;
              count_next = '0;
            end
            default: begin
              // Unused code: accepted and ignored.
            end
          endcase
        end
      end
      dq_pkg::S_POP: begin
        // Read data arrived; the pointers were already updated on accept.
        if (out_free) begin
          load       = 1'b1;
          ld_value   = rd_data;
          state_next = dq_pkg::S_IDLE;
        end
      end
      dq_pkg::S_WALK: begin
        // Load the word held in the read register and fetch the next one at once.
        if (out_free) begin
          load     = 1'b1;
          ld_value = rd_data;
          ld_last  = walk_is_last;
          if (walk_is_last) begin
            state_next = dq_pkg::S_IDLE;
          end else begin
            walk_idx_next = walk_nxt;
            rd_en         = 1'b1;
            rd_addr       = slot(head, walk_off[IW-1:0]);
          end
        end
      end
      default: begin
        state_next = dq_pkg::S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dq_pkg::S_IDLE;
      head     <= '0;
      count    <= '0;
      walk_idx <= '0;
      walk_rev <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      count    <= count_next;
      walk_idx <= walk_idx_next;
      walk_rev <= walk_rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // The occupancy reported is the count after the request takes effect.
  always_ff @(posedge clk) begin
    if (load) begin
      out_value  <= ld_value;
      out_status <= ld_status;
      out_last   <= ld_last;
      out_occ    <= count_next;
    end
  end

  // Word memory. The read register holds its data until the next read, so a
  // stalled result side loses nothing.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.value     = out_value;
  assign rsp.status    = out_status;
  assign rsp.last      = out_last;
  assign rsp.occupancy = out_occ;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("occupancy count exceeds depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !full &&
     (req.req_type == dq_pkg::REQ_PUSH_HEAD || req.req_type == dq_pkg::REQ_PUSH_TAIL))
    |=> (count == $past(count) + CW'(1)) && out_valid)
    else $error("accepted push did not add a word and a result");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && !empty &&
     (req.req_type == dq_pkg::REQ_POP_HEAD || req.req_type == dq_pkg::REQ_POP_TAIL))
    |=> (count == $past(count) - CW'(1)) && (state == dq_pkg::S_POP))
    else $error("accepted pop did not remove a word");

endmodule

`default_nettype wire
